### rtl/core/per_process_block_allocator_assert.svh
// assertion macros for the per-process block allocator
`ifndef PER_PROCESS_BLOCK_ALLOCATOR_ASSERT_SVH
`define PER_PROCESS_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PPBA_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ppba assertion failed");
`define PPBA_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ppba assertion failed");
`else
`define PPBA_ASSERT(label, expr)
`define PPBA_ASSERT_IMP(label, pre, post)
`endif
`endif

### rtl/core/ppba_pkg.sv
package ppba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = 6;
    localparam int ADDR_W     = 16;
    localparam int CAP_W      = ADDR_W + 1;
    localparam int OWNER_W    = 7;

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_ACCESS = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FAULT     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;

    typedef struct packed {
        logic [1:0]         action;
        logic [OWNER_W-1:0] owner_process;
        logic [ADDR_W-1:0]  request_size;
        logic [ADDR_W-1:0]  request_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [2:0]        status;
    } rsp_t;

    // running result of one sweep along the cells
    typedef struct packed {
        logic              go;
        logic              ue_f;
        logic [IDX_W-1:0]  ue_i;
        logic              fe_f;
        logic [IDX_W-1:0]  fe_i;
        logic              bf_f;
        logic [IDX_W-1:0]  bf_i;
        logic [CAP_W-1:0]  bf_cap;
        logic [CAP_W-1:0]  bf_base;
        logic              fm_f;
        logic [IDX_W-1:0]  fm_i;
        logic [CAP_W-1:0]  fm_base;
        logic [CAP_W-1:0]  fm_cap;
        logic              own_f;
        logic [IDX_W-1:0]  own_i;
        logic [CAP_W-1:0]  own_base;
        logic [CAP_W-1:0]  own_cap;
        logic              hit;
    } tok_t;

    // table update broadcast to all cells
    typedef struct packed {
        logic               uw_en;
        logic [IDX_W-1:0]   uw_idx;
        logic [OWNER_W-1:0] uw_owner;
        logic [CAP_W-1:0]   uw_base;
        logic [ADDR_W-1:0]  uw_len;
        logic [CAP_W-1:0]   uw_cap;
        logic               uc_en;
        logic [IDX_W-1:0]   uc_idx;
        logic               fw_en;
        logic [IDX_W-1:0]   fw_idx;
        logic [CAP_W-1:0]   fw_base;
        logic [CAP_W-1:0]   fw_cap;
        logic               fc_en;
        logic [IDX_W-1:0]   fc_idx;
    } cmd_t;

endpackage

### rtl/core/ppba_cell.sv
module ppba_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [ppba_pkg::IDX_W-1:0] idx,
    input  ppba_pkg::req_t          req,
    input  ppba_pkg::cmd_t          cmd,
    input  ppba_pkg::tok_t          tok_in,
    output ppba_pkg::tok_t          tok_out
);
    import ppba_pkg::*;

    logic               used_valid_reg;
    logic [OWNER_W-1:0] used_owner_reg;
    logic [CAP_W-1:0]   used_base_reg;
    logic [ADDR_W-1:0]  used_len_reg;
    logic [CAP_W-1:0]   used_cap_reg;
    logic               free_valid_reg;
    logic [CAP_W-1:0]   free_base_reg;
    logic [CAP_W-1:0]   free_cap_reg;
    logic               go_reg;
    tok_t               tok_reg;
    tok_t               tok_next;
    logic               own;
    logic               cand;
    logic [CAP_W:0]     end_addr;

    always_comb
    begin
        own      = used_valid_reg && (used_owner_reg == req.owner_process);
        cand     = free_valid_reg && (free_cap_reg >= {1'b0, req.request_size});
        end_addr = {1'b0, used_base_reg} + {2'b0, used_len_reg};
        tok_next = tok_in;
        if (!tok_in.ue_f && !used_valid_reg)
        begin
            tok_next.ue_f = 1'b1;
            tok_next.ue_i = idx;
        end
        if (!tok_in.fe_f && !free_valid_reg)
        begin
            tok_next.fe_f = 1'b1;
            tok_next.fe_i = idx;
        end
        if (cand && (!tok_in.bf_f || free_cap_reg < tok_in.bf_cap ||
                     (free_cap_reg == tok_in.bf_cap && free_base_reg < tok_in.bf_base)))
        begin
            tok_next.bf_f    = 1'b1;
            tok_next.bf_i    = idx;
            tok_next.bf_cap  = free_cap_reg;
            tok_next.bf_base = free_base_reg;
        end
        if (!tok_in.fm_f && own && used_base_reg == {1'b0, req.request_address})
        begin
            tok_next.fm_f    = 1'b1;
            tok_next.fm_i    = idx;
            tok_next.fm_base = used_base_reg;
            tok_next.fm_cap  = used_cap_reg;
        end
        if (!tok_in.own_f && own)
        begin
            tok_next.own_f    = 1'b1;
            tok_next.own_i    = idx;
            tok_next.own_base = used_base_reg;
            tok_next.own_cap  = used_cap_reg;
        end
        if (own && {1'b0, req.request_address} >= used_base_reg &&
            {2'b0, req.request_address} < end_addr)
        begin
            tok_next.hit = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_valid_reg <= 1'b0;
            free_valid_reg <= 1'b0;
            go_reg         <= 1'b0;
        end
        else
        begin
            go_reg <= tok_in.go;
            if (cmd.uw_en && cmd.uw_idx == idx)
                used_valid_reg <= 1'b1;
            else if (cmd.uc_en && cmd.uc_idx == idx)
                used_valid_reg <= 1'b0;
            if (cmd.fw_en && cmd.fw_idx == idx)
                free_valid_reg <= 1'b1;
            else if (cmd.fc_en && cmd.fc_idx == idx)
                free_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (cmd.uw_en && cmd.uw_idx == idx)
        begin
            used_owner_reg <= cmd.uw_owner;
            used_base_reg  <= cmd.uw_base;
            used_len_reg   <= cmd.uw_len;
            used_cap_reg   <= cmd.uw_cap;
        end
        if (cmd.fw_en && cmd.fw_idx == idx)
        begin
            free_base_reg <= cmd.fw_base;
            free_cap_reg  <= cmd.fw_cap;
        end
    end

    always_comb
    begin
        tok_out    = tok_reg;
        tok_out.go = go_reg;
    end

endmodule

### rtl/core/per_process_block_allocator.sv
// Per-process best-fit block allocator. Each request (allocate, free, access check) starts a
// sweep of a token along a chain of 64 cells, one cell per cycle, each cell holding one used
// slot and one free slot; the token collects first empty slots, the best-fitting freed block,
// the matching block and the access hit, and the table update is applied when it leaves the
// last cell. Allocate, free and a hitting access take one sweep from transfer in to response;
// a faulting access takes one further sweep per block the process owns; the unused action
// code skips the sweep and answers directly. A new request is taken only once the previous
// one has left the sweep; the response register lets a waiting response sit while the next
// request is taken.
module per_process_block_allocator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ppba_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ppba_pkg::rsp_t rsp
);
    import ppba_pkg::*;
`include "per_process_block_allocator_assert.svh"

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0]       state_reg, state_next;
    req_t             req_reg, req_next;
    logic [CAP_W-1:0] fresh_reg, fresh_next;
    logic             launch_reg, launch_next;
    rsp_t             res_reg, res_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;
    cmd_t             cmd;
    tok_t             chain [0:MAX_BLOCKS];
    tok_t             last;
    logic [CAP_W:0]   fresh_sum;

    // token entering the first cell
    always_comb
    begin
        chain[0]    = '0;
        chain[0].go = launch_reg;
    end

    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        ppba_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (IDX_W'(i)),
            .req     (req_reg),
            .cmd     (cmd),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign last      = chain[MAX_BLOCKS];
    assign fresh_sum = {1'b0, fresh_reg} + {2'b0, req_reg.request_size};

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        fresh_next     = fresh_reg;
        launch_next    = 1'b0;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        cmd            = '0;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    res_next = '0;
                    if (req.action == ACT_NONE)
                        state_next = S_DONE;
                    else
                    begin
                        launch_next = 1'b1;
                        state_next  = S_SWEEP;
                    end
                end
            end
            S_SWEEP:
            begin
                if (last.go)
                begin
                    state_next = S_DONE;
                    case (req_reg.action)
                        ACT_ALLOC:
                        begin
                            if (!last.ue_f)
                                res_next.status = ST_FULL;
                            else if (last.bf_f)
                            begin
                                cmd.uw_en  = 1'b1;
                                cmd.uw_base = last.bf_base;
                                cmd.uw_cap = last.bf_cap;
                                cmd.fc_en  = 1'b1;
                                cmd.fc_idx = last.bf_i;
                                res_next.result_address = last.bf_base[ADDR_W-1:0];
                            end
                            else if (fresh_sum > {2'b01, {ADDR_W{1'b0}}})
                                res_next.status = ST_EXHAUSTED;
                            else
                            begin
                                cmd.uw_en  = 1'b1;
                                cmd.uw_base = fresh_reg;
                                cmd.uw_cap = {1'b0, req_reg.request_size};
                                fresh_next = fresh_sum[CAP_W-1:0];
                                res_next.result_address = fresh_reg[ADDR_W-1:0];
                            end
                            cmd.uw_idx   = last.ue_i;
                            cmd.uw_owner = req_reg.owner_process;
                            cmd.uw_len   = req_reg.request_size;
                        end
                        ACT_FREE:
                        begin
                            if (!last.fm_f)
                                res_next.status = ST_NOT_FOUND;
                            else if (!last.fe_f)
                                res_next.status = ST_FULL;
                            else
                            begin
                                cmd.uc_en   = 1'b1;
                                cmd.uc_idx  = last.fm_i;
                                cmd.fw_en   = 1'b1;
                                cmd.fw_idx  = last.fe_i;
                                cmd.fw_base = last.fm_base;
                                cmd.fw_cap  = last.fm_cap;
                            end
                        end
                        ACT_ACCESS:
                        begin
                            if (!last.hit)
                            begin
                                // fault: retire one block per sweep until none is left
                                res_next.status = ST_FAULT;
                                if (last.own_f)
                                begin
                                    cmd.uc_en   = 1'b1;
                                    cmd.uc_idx  = last.own_i;
                                    cmd.fw_en   = last.fe_f;
                                    cmd.fw_idx  = last.fe_i;
                                    cmd.fw_base = last.own_base;
                                    cmd.fw_cap  = last.own_cap;
                                    launch_next = 1'b1;
                                    state_next  = S_SWEEP;
                                end
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_OK;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fresh_reg     <= '0;
            launch_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fresh_reg     <= fresh_next;
            launch_reg    <= launch_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // fresh mark never runs past the top of the address space
    `PPBA_ASSERT(a_fresh_bound, fresh_reg <= {1'b1, {ADDR_W{1'b0}}})
    // a sweep is launched only while sweeping
    `PPBA_ASSERT_IMP(a_launch_sweep, launch_reg, state_reg == S_SWEEP)
    // a response appears only when leaving the done state
    `PPBA_ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_reg), $past(state_reg) == S_DONE)
    // the token never arrives outside a sweep
    `PPBA_ASSERT_IMP(a_token_sweep, last.go, state_reg == S_SWEEP)

endmodule

### tb/ppba_checker.sv
module ppba_checker
    import ppba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow allocator tables
    logic [CAP_W-1:0]   fresh_mark;
    bit                 used_v    [MAX_BLOCKS];
    logic [OWNER_W-1:0] used_own  [MAX_BLOCKS];
    logic [CAP_W-1:0]   used_base [MAX_BLOCKS];
    logic [ADDR_W-1:0]  used_len  [MAX_BLOCKS];
    logic [CAP_W-1:0]   used_cap  [MAX_BLOCKS];
    bit                 free_v    [MAX_BLOCKS];
    logic [CAP_W-1:0]   free_base [MAX_BLOCKS];
    logic [CAP_W-1:0]   free_cap  [MAX_BLOCKS];

    rsp_t expected_rsp[$];

    assign pending = expected_rsp.size();

    function automatic bit retire_block(int u);
        for (int f = 0; f < MAX_BLOCKS; f++)
        begin
            if (!free_v[f])
            begin
                free_v[f]    = 1'b1;
                free_base[f] = used_base[u];
                free_cap[f]  = used_cap[u];
                used_v[u]    = 1'b0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic rsp_t predict_response(req_t r);
        rsp_t o;
        int   u;
        int   best;
        bit   hit;
        o    = '0;
        u    = -1;
        best = -1;
        hit  = 1'b0;
        o.status = ST_OK;
        case (r.action)
            ACT_ALLOC:
            begin
                for (int i = MAX_BLOCKS - 1; i >= 0; i--)
                    if (!used_v[i]) u = i;
                if (u < 0)
                    o.status = ST_FULL;
                else
                begin
                    for (int i = 0; i < MAX_BLOCKS; i++)
                    begin
                        if (!free_v[i] || free_cap[i] < {1'b0, r.request_size})
                            continue;
                        if (best < 0 || free_cap[i] < free_cap[best] ||
                            (free_cap[i] == free_cap[best] && free_base[i] < free_base[best]))
                            best = i;
                    end
                    if (best >= 0)
                    begin
                        used_base[u]  = free_base[best];
                        used_cap[u]   = free_cap[best];
                        free_v[best]  = 1'b0;
                    end
                    else if ({1'b0, fresh_mark} + r.request_size > (1 << ADDR_W))
                        o.status = ST_EXHAUSTED;
                    else
                    begin
                        used_base[u] = fresh_mark;
                        used_cap[u]  = {1'b0, r.request_size};
                        fresh_mark   = fresh_mark + {1'b0, r.request_size};
                    end
                    if (o.status == ST_OK)
                    begin
                        used_v[u]        = 1'b1;
                        used_own[u]      = r.owner_process;
                        used_len[u]      = r.request_size;
                        o.result_address = used_base[u][ADDR_W-1:0];
                    end
                end
            end
            ACT_FREE:
            begin
                o.status = ST_NOT_FOUND;
                for (int i = 0; i < MAX_BLOCKS; i++)
                begin
                    if (used_v[i] && used_own[i] == r.owner_process &&
                        used_base[i] == {1'b0, r.request_address})
                    begin
                        o.status = retire_block(i) ? ST_OK : ST_FULL;
                        break;
                    end
                end
            end
            ACT_ACCESS:
            begin
                for (int i = 0; i < MAX_BLOCKS; i++)
                    if (used_v[i] && used_own[i] == r.owner_process &&
                        {1'b0, r.request_address} >= used_base[i] &&
                        {2'b0, r.request_address} < {1'b0, used_base[i]} + {2'b0, used_len[i]})
                        hit = 1'b1;
                if (!hit)
                begin
                    // miss: every block of the process goes, dropped if no free slot
                    for (int i = 0; i < MAX_BLOCKS; i++)
                        if (used_v[i] && used_own[i] == r.owner_process)
                            if (!retire_block(i))
                                used_v[i] = 1'b0;
                    o.status = ST_FAULT;
                end
            end
            default: o.status = ST_OK;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            fresh_mark = '0;
            foreach (used_v[i])
            begin
                used_v[i] = 1'b0;
                free_v[i] = 1'b0;
            end
            expected_rsp.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("unexpected response, status", rsp.status, -1);
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.result_address !== want.result_address)
                        report_mismatch("result_address", rsp.result_address,
                                        want.result_address);
                end
            end
            if (req_valid && req_ready)
                expected_rsp.push_back(predict_response(req));
        end
    end

    initial errors = 0;

endmodule

### tb/tb_per_process_block_allocator.sv
module tb_per_process_block_allocator;
    import ppba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4_000_000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    int   errors;
    int   pending;

    // idling percentages of the current phase
    int   send_idle_pct;
    int   recv_stall_pct;
    // long receiver hold-off, requested by the stimulus, counted by the receiver
    int   hold_reqs;
    int   hold_seen;
    int   hold_left;
    int   cycles;

    // requests in flight and blocks believed granted, used to aim frees and accesses
    req_t in_flight[$];
    logic [OWNER_W-1:0] blk_own[$];
    logic [ADDR_W-1:0]  blk_base[$];
    logic [ADDR_W-1:0]  blk_size[$];

    per_process_block_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    ppba_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb_per_process_block_allocator failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus the occasional long hold-off
    initial
    begin
        rsp_ready = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // track granted blocks from the transfers seen on both channels
    always @(posedge clk)
    begin
        req_t r;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready && in_flight.size() > 0)
            begin
                r = in_flight.pop_front();
                if (r.action == ACT_ALLOC && rsp.status == ST_OK)
                begin
                    blk_own.push_back(r.owner_process);
                    blk_base.push_back(rsp.result_address);
                    blk_size.push_back(r.request_size);
                end
                else if ((r.action == ACT_FREE && rsp.status == ST_OK) ||
                         (r.action == ACT_ACCESS && rsp.status == ST_FAULT))
                begin
                    for (int i = blk_own.size() - 1; i >= 0; i--)
                        if (blk_own[i] == r.owner_process &&
                            (r.action == ACT_ACCESS || blk_base[i] == r.request_address))
                        begin
                            blk_own.delete(i);
                            blk_base.delete(i);
                            blk_size.delete(i);
                        end
                end
            end
            if (req_valid && req_ready)
                in_flight.push_back(req);
        end
    end

    // offer one request and hold it until the transfer
    task automatic send(logic [1:0] act, logic [OWNER_W-1:0] own,
                        logic [ADDR_W-1:0] size, logic [ADDR_W-1:0] addr);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid           <= 1'b1;
        req.action          <= act;
        req.owner_process   <= own;
        req.request_size    <= size;
        req.request_address <= addr;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = req_ready;
            @(posedge clk);
        end
    endtask

    task automatic send_random();
        int k;
        int pick;
        int sel;
        logic [OWNER_W-1:0] own;
        logic [ADDR_W-1:0]  size;
        logic [ADDR_W-1:0]  addr;
        k    = $urandom_range(99);
        pick = $urandom_range(99);
        sel  = $urandom_range(99);
        own  = (sel < 85) ? OWNER_W'($urandom_range(7)) : OWNER_W'($urandom_range(127));
        addr = ADDR_W'($urandom_range(65535));
        if (sel < 90)
            size = ADDR_W'($urandom_range(64, 1));
        else if (sel < 93)
            size = '0;
        else
            size = ADDR_W'($urandom_range(65535));
        if (k < 40)
            send(ACT_ALLOC, own, size, addr);
        else if (k < 95)
        begin
            // aim at a known block most of the time
            if (pick < 75 && blk_own.size() > 0)
            begin
                sel  = $urandom_range(blk_own.size() - 1);
                own  = blk_own[sel];
                addr = blk_base[sel];
                if (k >= 65 && blk_size[sel] > 1)
                    addr = addr + ADDR_W'($urandom_range(blk_size[sel] - 1));
            end
            send((k < 65) ? ACT_FREE : ACT_ACCESS, own, size, addr);
        end
        else
            send(ACT_NONE, own, size, addr);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_reqs      = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unused code, empty process, zero size, best fit, ties, exhaustion
        send(ACT_NONE,   7'd0,   16'd5,     16'd5);
        send(ACT_ACCESS, 7'd9,   16'd0,     16'd0);
        send(ACT_ALLOC,  7'd1,   16'd0,     16'd0);
        send(ACT_ACCESS, 7'd1,   16'd0,     16'd0);
        send(ACT_ALLOC,  7'd2,   16'd64,    16'd0);
        send(ACT_ALLOC,  7'd127, 16'd1,     16'hffff);
        send(ACT_ACCESS, 7'd2,   16'd0,     16'd63);
        send(ACT_ACCESS, 7'd2,   16'd0,     16'd64);
        send(ACT_FREE,   7'd3,   16'd0,     16'd1234);
        send(ACT_ALLOC,  7'd3,   16'd100,   16'd0);
        send(ACT_FREE,   7'd3,   16'd0,     16'd65);
        send(ACT_ALLOC,  7'd4,   16'd50,    16'd0);
        send(ACT_ALLOC,  7'd5,   16'd64,    16'd0);
        send(ACT_ALLOC,  7'd6,   16'hffff,  16'hffff);
        send(ACT_FREE,   7'd5,   16'd0,     16'd65);
        send(ACT_FREE,   7'd5,   16'd0,     16'd65);
        send(ACT_ALLOC,  7'd7,   16'd64,    16'd0);
        send(ACT_FREE,   7'd7,   16'd0,     16'd165);
        send(ACT_FREE,   7'd4,   16'd0,     16'd0);
        send(ACT_ALLOC,  7'd8,   16'd10,    16'd0);
        send(ACT_ACCESS, 7'd127, 16'hffff,  16'd64);
        send(ACT_ACCESS, 7'd127, 16'd0,     16'hffff);

        // random phases with different idling
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = (p == 1 || p == 3) ? ((p == 3) ? 28 : 46) : 0;
            recv_stall_pct = (p == 2 || p == 3) ? ((p == 3) ? 28 : 46) : 0;
            if (p == 1)
            begin
                // fill the used table to overflow, then fault it into the free table
                for (int n = 0; n < 70; n++)
                    send(ACT_ALLOC, OWNER_W'($urandom_range(7)),
                         ADDR_W'($urandom_range(4, 1)), 16'd0);
                for (int n = 0; n < 8; n++)
                    send(ACT_ACCESS, OWNER_W'(n), 16'd0, 16'hffff);
            end
            if (p == 2)
                hold_reqs++;
            for (int n = 0; n < 130; n++)
                send_random();
        end

        req_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (errors == 0)
            $display("tb_per_process_block_allocator passed");
        else
            $display("tb_per_process_block_allocator failed");
        $finish;
    end

endmodule
